FILE: src/sjis_pkg.sv
package sjis_pkg;

    // Two-byte encodings selected by the mode register.
    localparam logic [1:0] MODE_JIS  = 2'd0;
    localparam logic [1:0] MODE_SJIS = 2'd1;
    localparam logic [1:0] MODE_EUC  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FONT_SIZE   = 2'd0;
    localparam logic [1:0] REG_GLYPH_COUNT = 2'd1;
    localparam logic [1:0] REG_CODE_MODE   = 2'd2;

    localparam logic [7:0]  FONT_SIZE_RESET = 8'd16;
    localparam logic [7:0]  CHAR_NUL        = 8'h00;
    localparam logic [7:0]  CHAR_LF         = 8'h0A;
    localparam logic [7:0]  JIS_OFFSET      = 8'h20;
    localparam logic [7:0]  ROW_LENGTH      = 8'd96;
    localparam logic [7:0]  KANJI_FIRST     = 8'hFF;

    // A pair (c1, c2) maps to c1*96 + c2 - KANJI_BASE.
    localparam logic [15:0] KANJI_BASE =
        16'(32'(JIS_OFFSET) * 32'(ROW_LENGTH) + 32'(JIS_OFFSET) - 32'(KANJI_FIRST));

    typedef struct packed {
        logic [7:0]  font_size;
        logic [14:0] glyph_count;
        logic [1:0]  code_mode;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic [14:0] index;
    } pair_glyph_t;

endpackage

FILE: src/sjis_regs.sv
module sjis_regs
    import sjis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.font_size   <= FONT_SIZE_RESET;
            cfg_reg.glyph_count <= '0;
            cfg_reg.code_mode   <= MODE_JIS;
        end else if (wr_en) begin
            case (reg_index)
                REG_FONT_SIZE:   cfg_reg.font_size   <= pwdata[7:0];
                REG_GLYPH_COUNT: cfg_reg.glyph_count <= pwdata[14:0];
                REG_CODE_MODE:   cfg_reg.code_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_FONT_SIZE:   prdata = {24'd0, cfg_reg.font_size};
            REG_GLYPH_COUNT: prdata = {17'd0, cfg_reg.glyph_count};
            REG_CODE_MODE:   prdata = {30'd0, cfg_reg.code_mode};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: src/sjis_pair_decode.sv
module sjis_pair_decode
    import sjis_pkg::*;
(
    input  logic [7:0]  lead,
    input  logic [7:0]  trail,
    input  logic [1:0]  code_mode,
    input  logic [14:0] glyph_count,
    output pair_glyph_t glyph
);

    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  row2;
    logic [15:0] linear;
    logic [15:0] offset;

    always_comb begin
        // Shift-JIS folds two JIS rows into each lead byte; all steps wrap at 8 bits.
        s1 = (lead >= 8'hE0) ? lead - 8'h40 : lead;
        s2 = (trail >= 8'h80) ? trail - 8'h01 : trail;
        row2 = 8'((s1 - 8'h70) << 1);
        case (code_mode)
            MODE_SJIS: begin
                if (s2 >= 8'h9E) begin
                    c1 = row2;
                    c2 = s2 - 8'h7D;
                end else begin
                    c1 = row2 - 8'h01;
                    c2 = s2 - 8'h1F;
                end
            end
            MODE_EUC: begin
                c1 = lead - 8'h80;
                c2 = trail - 8'h80;
            end
            default: begin
                c1 = lead;
                c2 = trail;
            end
        endcase

        // c1*96 as two shifted copies.
        linear = {2'b00, c1, 6'd0} + {3'b000, c1, 5'd0} + {8'd0, c2};
        offset = linear - KANJI_BASE;
        glyph.index = offset[14:0];
        glyph.hit   = (linear >= KANJI_BASE) && (offset < {1'b0, glyph_count});
    end

endmodule

FILE: src/sjis_euc_text_to_glyph_index.sv
// Text byte to glyph draw command converter.
// Input channel (s_*): one text byte per word with string_start and the
// string origin. A zero byte ends the string. Printable ASCII draws a
// half-width glyph, a newline moves to the next line, any other byte is
// the lead of a two-byte character decoded per code_mode.
// Result channel (m_*): glyph index, raster position and width flag. Bytes
// that draw nothing (lead bytes, newline, terminator, glyphs outside
// glyph_count) produce no result word.
// The APB port holds font_size (0x0), glyph_count (0x4) and code_mode (0x8);
// write it only while no byte is in flight.
// Each accepted byte passes the input register, then the result register.
// One byte is taken every cycle unless the receiver stalls; the rate is
// set by the cursor and lead-byte state, updated from the input register.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the cursor state and empties both pipeline registers.
// When the receiver stalls, the result register holds its word; the input
// register keeps one more byte, then s_ready drops until m_ready returns.
module sjis_euc_text_to_glyph_index
    import sjis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_string_start,
    input  logic signed [15:0] s_start_x,
    input  logic signed [15:0] s_start_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_glyph_index,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic               m_full_width
);

    cfg_t        cfg;
    pair_glyph_t pair;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic [15:0] start_x_reg;
    logic [15:0] start_y_reg;

    logic        pending_reg, pending_next;
    logic [7:0]  lead_reg, lead_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [15:0] origin_y_reg, origin_y_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] cursor_reg, cursor_next;

    logic        out_valid_reg;
    logic [14:0] index_reg, index_next;
    logic [15:0] pos_x_reg;
    logic [15:0] pos_y_reg, pos_y_next;
    logic        full_reg, full_next;

    logic        advance;
    logic        fire;
    logic        emit;
    logic        pending_eff;
    logic [15:0] line_eff;
    logic [15:0] cursor_eff;

    sjis_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sjis_pair_decode u_decode (
        .lead        (lead_reg),
        .trail       (byte_reg),
        .code_mode   (cfg.code_mode),
        .glyph_count (cfg.glyph_count),
        .glyph       (pair)
    );

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        // A string start reloads the origin before the byte itself is handled.
        if (start_reg) begin
            origin_x_next = start_x_reg;
            origin_y_next = start_y_reg;
            cursor_eff    = start_x_reg;
            line_eff      = '0;
            pending_eff   = 1'b0;
        end else begin
            origin_x_next = origin_x_reg;
            origin_y_next = origin_y_reg;
            cursor_eff    = cursor_reg;
            line_eff      = line_reg;
            pending_eff   = pending_reg;
        end

        pending_next = 1'b0;
        lead_next    = lead_reg;
        line_next    = line_eff;
        cursor_next  = cursor_eff;
        emit         = 1'b0;
        index_next   = {7'd0, byte_reg};
        full_next    = 1'b0;
        pos_y_next   = origin_y_next + {8'd0, cfg.font_size} + line_eff;

        if (byte_reg == CHAR_NUL) begin
            emit = 1'b0;
        end else if (pending_eff) begin
            // Any nonzero byte completes a pending pair.
            index_next = pair.index;
            full_next  = 1'b1;
            if (pair.hit) begin
                emit        = 1'b1;
                cursor_next = cursor_eff + {8'd0, cfg.font_size};
            end
        end else if (byte_reg == CHAR_LF) begin
            line_next   = line_eff + {8'd0, cfg.font_size} + 16'd1;
            cursor_next = origin_x_next;
        end else if (byte_reg inside {[8'h20:8'h7E]}) begin
            if ({7'd0, byte_reg} < cfg.glyph_count) begin
                emit        = 1'b1;
                cursor_next = cursor_eff + {9'd0, cfg.font_size[7:1]};
            end
        end else begin
            pending_next = 1'b1;
            lead_next    = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            lead_reg      <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            line_reg      <= '0;
            cursor_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= emit;
                pending_reg   <= pending_next;
                lead_reg      <= lead_next;
                origin_x_reg  <= origin_x_next;
                origin_y_reg  <= origin_y_next;
                line_reg      <= line_next;
                cursor_reg    <= cursor_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg    <= s_text_byte;
            start_reg   <= s_string_start;
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
        end
        if (fire && emit) begin
            index_reg <= index_next;
            pos_x_reg <= cursor_eff;
            pos_y_reg <= pos_y_next;
            full_reg  <= full_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_glyph_index = index_reg;
    assign m_pos_x       = $signed(pos_x_reg);
    assign m_pos_y       = $signed(pos_y_reg);
    assign m_full_width  = full_reg;

endmodule
